@@ rtl/tcp_flow_tracker_defines.svh @@
// Assertion helpers shared by the flow tracker RTL.
// Each macro expects clk_i and rst_ni in scope.
`ifndef TCP_FLOW_TRACKER_DEFINES_SVH
`define TCP_FLOW_TRACKER_DEFINES_SVH

// Same-cycle implication.
`define TFT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TFT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tft_pkg.sv @@
// ----------------------------------------------------------------------------
// tft_pkg
// Types, codes and helpers for the TCP flow tracker.
// ----------------------------------------------------------------------------
package tft_pkg;

  localparam int unsigned SETS_DEF = 1024;
  localparam int unsigned WAYS_DEF = 4;

  // teardown state codes
  localparam logic [3:0] ST_CLOSED     = 4'h0;
  localparam logic [3:0] ST_ESTAB      = 4'h3;
  localparam logic [3:0] ST_FIN_WAIT_1 = 4'h4;
  localparam logic [3:0] ST_CLOSE_WAIT = 4'h5;
  localparam logic [3:0] ST_FIN_WAIT_2 = 4'h6;
  localparam logic [3:0] ST_LAST_ACK   = 4'h7;
  localparam logic [3:0] ST_TIME_WAIT  = 4'h8;

  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_DRAIN  = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] payload_len;
    logic        fin_flag;
    logic        ack_flag;
  } in_t;

  typedef struct packed {
    logic        record_valid;
    logic [31:0] flow_src_ip;
    logic [15:0] flow_src_port;
    logic [31:0] flow_dst_ip;
    logic [15:0] flow_dst_port;
    logic [31:0] up_bytes;
    logic [31:0] down_bytes;
    logic [31:0] up_packets;
    logic [31:0] down_packets;
    logic [3:0]  final_state;
    logic        dropped;
    logic        table_empty;
  } out_t;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] up_bytes;
    logic [31:0] down_bytes;
    logic [31:0] up_packets;
    logic [31:0] down_packets;
    logic [3:0]  tstate;
  } entry_t;

  typedef enum logic [2:0] {
    CS_CLEAR,
    CS_IDLE,
    CS_HASH,
    CS_DIV,
    CS_READ,
    CS_UPDATE,
    CS_SCAN
  } ctl_state_e;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hffff_ffff : s[31:0];
  endfunction

endpackage

@@ rtl/tcp_flow_tracker.sv @@
// ----------------------------------------------------------------------------
// tcp_flow_tracker: set-associative TCP flow table with teardown tracking.
// Packet: result registered after the hash, divide, set read and update
// steps; the next transaction is taken only once the block is idle again.
// Drain: one set row read per cycle from the drain position until a valid
// way is found or the whole table is seen. A stalled result holds the final
// step. Reset runs a pass clearing the valid memory; input is stalled.
// ----------------------------------------------------------------------------
`include "tcp_flow_tracker_defines.svh"

module tcp_flow_tracker #(
  parameter int unsigned SETS = tft_pkg::SETS_DEF,
  parameter int unsigned WAYS = tft_pkg::WAYS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  tft_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output tft_pkg::out_t out_data_o
);

  localparam int unsigned RB = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WB = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned CB = $clog2(SETS + 1);

  tft_pkg::ctl_state_e state_q, state_d;

  tft_pkg::in_t  in_q;
  tft_pkg::out_t out_q, res;
  logic          out_valid_q;
  logic          out_free, out_load, accept;

  logic [RB-1:0] set_idx;
  logic [RB-1:0] clr_row_q, clr_row_d;
  logic [RB-1:0] scan_row_q, scan_row_d, scan_row_nx;
  logic [CB-1:0] scan_cnt_q, scan_cnt_d;
  logic [RB-1:0] cur_row_q, cur_row_d;
  logic [WB-1:0] cur_way_q, cur_way_d;

  // memories
  logic [WAYS-1:0]                  vld_mem [SETS];
  tft_pkg::entry_t [WAYS-1:0]       dat_mem [SETS];
  logic [WAYS-1:0]                  vld_rd_q, vld_wd;
  tft_pkg::entry_t [WAYS-1:0]       dat_rd_q, dat_wd;
  logic                             vld_we, dat_we, rd_en;
  logic [RB-1:0]                    wr_addr, rd_addr;

  // update path
  logic [WAYS-1:0]            up_m, dn_m;
  logic                       hit, hit_up, has_free;
  logic [WB-1:0]              hw, fw;
  tft_pkg::entry_t            e_old, e_new;
  tft_pkg::entry_t [WAYS-1:0] upd_row;
  logic [WAYS-1:0]            upd_vld;
  tft_pkg::out_t              upd_res;

  // drain path
  logic [WAYS-1:0] scan_m;
  logic            d_found;
  logic [WB-1:0]   dw;
  tft_pkg::entry_t d_ent;

  tft_set_index #(.SETS(SETS)) u_set_index (
    .clk_i     (clk_i),
    .tuple_i   (in_q),
    .set_idx_o (set_idx)
  );

  assign accept      = in_valid_i && (state_q == tft_pkg::CS_IDLE);
  assign in_stall_o  = (state_q != tft_pkg::CS_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (vld_we) vld_mem[wr_addr] <= vld_wd;
    if (dat_we) dat_mem[wr_addr] <= dat_wd;
    if (rd_en) begin
      vld_rd_q <= vld_mem[rd_addr];
      dat_rd_q <= dat_mem[rd_addr];
    end
  end

  // ---- packet update ----
  always_comb begin
    hit      = 1'b0;
    hit_up   = 1'b0;
    has_free = 1'b0;
    hw       = '0;
    fw       = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      up_m[w] = vld_rd_q[w] &&
                dat_rd_q[w].src_ip == in_q.src_ip && dat_rd_q[w].dst_ip == in_q.dst_ip &&
                dat_rd_q[w].src_port == in_q.src_port &&
                dat_rd_q[w].dst_port == in_q.dst_port;
      dn_m[w] = vld_rd_q[w] &&
                dat_rd_q[w].dst_ip == in_q.src_ip && dat_rd_q[w].src_ip == in_q.dst_ip &&
                dat_rd_q[w].dst_port == in_q.src_port &&
                dat_rd_q[w].src_port == in_q.dst_port;
      if (up_m[w] || dn_m[w]) begin
        hit    = 1'b1;
        hit_up = up_m[w];
        hw     = WB'(w);
      end
      if (!vld_rd_q[w]) begin
        has_free = 1'b1;
        fw       = WB'(w);
      end
    end
  end

  always_comb begin
    e_old   = dat_rd_q[hw];
    e_new   = e_old;
    upd_row = dat_rd_q;
    upd_vld = vld_rd_q;
    upd_res = '0;
    if (hit) begin
      if (hit_up) begin
        e_new.up_bytes   = tft_pkg::sat_add(e_old.up_bytes, 32'(in_q.payload_len));
        e_new.up_packets = tft_pkg::sat_add(e_old.up_packets, 32'd1);
        priority if (e_old.tstate == tft_pkg::ST_ESTAB && in_q.fin_flag)
          e_new.tstate = tft_pkg::ST_FIN_WAIT_1;
        else if (e_old.tstate == tft_pkg::ST_TIME_WAIT && in_q.ack_flag)
          upd_res.record_valid = 1'b1;
        else if (e_old.tstate == tft_pkg::ST_CLOSE_WAIT && in_q.fin_flag)
          e_new.tstate = tft_pkg::ST_LAST_ACK;
        else
          e_new.tstate = e_old.tstate;
      end else begin
        e_new.down_bytes   = tft_pkg::sat_add(e_old.down_bytes, 32'(in_q.payload_len));
        e_new.down_packets = tft_pkg::sat_add(e_old.down_packets, 32'd1);
        priority if (e_old.tstate == tft_pkg::ST_ESTAB && in_q.fin_flag)
          e_new.tstate = tft_pkg::ST_CLOSE_WAIT;
        else if (e_old.tstate == tft_pkg::ST_LAST_ACK && in_q.ack_flag)
          upd_res.record_valid = 1'b1;
        else if (e_old.tstate == tft_pkg::ST_FIN_WAIT_1 && in_q.ack_flag)
          e_new.tstate = tft_pkg::ST_FIN_WAIT_2;
        else if (e_old.tstate == tft_pkg::ST_FIN_WAIT_2 && in_q.fin_flag)
          e_new.tstate = tft_pkg::ST_TIME_WAIT;
        else
          e_new.tstate = e_old.tstate;
      end
      upd_row[hw] = e_new;
      if (upd_res.record_valid) begin
        // closing packet: record includes it, entry freed
        upd_vld[hw]           = 1'b0;
        upd_res.flow_src_ip   = e_new.src_ip;
        upd_res.flow_src_port = e_new.src_port;
        upd_res.flow_dst_ip   = e_new.dst_ip;
        upd_res.flow_dst_port = e_new.dst_port;
        upd_res.up_bytes      = e_new.up_bytes;
        upd_res.down_bytes    = e_new.down_bytes;
        upd_res.up_packets    = e_new.up_packets;
        upd_res.down_packets  = e_new.down_packets;
        upd_res.final_state   = tft_pkg::ST_CLOSED;
      end
    end else if (has_free) begin
      upd_row[fw].src_ip       = in_q.src_ip;
      upd_row[fw].dst_ip       = in_q.dst_ip;
      upd_row[fw].src_port     = in_q.src_port;
      upd_row[fw].dst_port     = in_q.dst_port;
      upd_row[fw].up_bytes     = 32'(in_q.payload_len);
      upd_row[fw].down_bytes   = '0;
      upd_row[fw].up_packets   = 32'd1;
      upd_row[fw].down_packets = '0;
      upd_row[fw].tstate       = tft_pkg::ST_ESTAB;
      upd_vld[fw]              = 1'b1;
    end else begin
      upd_res.dropped = 1'b1;
    end
  end

  // ---- drain scan ----
  always_comb begin
    d_found = 1'b0;
    dw      = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (scan_cnt_q == '0)
        scan_m[w] = vld_rd_q[w] && (WB'(w) >= cur_way_q);
      else if (scan_cnt_q == CB'(SETS))
        scan_m[w] = vld_rd_q[w] && (WB'(w) < cur_way_q);
      else
        scan_m[w] = vld_rd_q[w];
      if (scan_m[w]) begin
        d_found = 1'b1;
        dw      = WB'(w);
      end
    end
    d_ent       = dat_rd_q[dw];
    scan_row_nx = (scan_row_q == RB'(SETS - 1)) ? '0 : scan_row_q + RB'(1);
  end

  // ---- control ----
  always_comb begin
    state_d    = state_q;
    clr_row_d  = clr_row_q;
    scan_row_d = scan_row_q;
    scan_cnt_d = scan_cnt_q;
    cur_row_d  = cur_row_q;
    cur_way_d  = cur_way_q;
    vld_we     = 1'b0;
    dat_we     = 1'b0;
    vld_wd     = vld_rd_q;
    dat_wd     = dat_rd_q;
    wr_addr    = set_idx;
    rd_en      = 1'b0;
    rd_addr    = set_idx;
    out_load   = 1'b0;
    res        = '0;
    unique case (state_q)
      tft_pkg::CS_CLEAR: begin
        vld_we    = 1'b1;
        vld_wd    = '0;
        wr_addr   = clr_row_q;
        clr_row_d = clr_row_q + RB'(1);
        if (clr_row_q == RB'(SETS - 1)) state_d = tft_pkg::CS_IDLE;
      end
      tft_pkg::CS_IDLE: begin
        if (accept) begin
          if (in_data_i.op == tft_pkg::OP_DRAIN) begin
            rd_en      = 1'b1;
            rd_addr    = cur_row_q;
            scan_row_d = cur_row_q;
            scan_cnt_d = '0;
            state_d    = tft_pkg::CS_SCAN;
          end else begin
            state_d = tft_pkg::CS_HASH;
          end
        end
      end
      tft_pkg::CS_HASH: state_d = tft_pkg::CS_DIV;
      tft_pkg::CS_DIV:  state_d = tft_pkg::CS_READ;
      tft_pkg::CS_READ: begin
        rd_en   = 1'b1;
        state_d = tft_pkg::CS_UPDATE;
      end
      tft_pkg::CS_UPDATE: begin
        // read data holds until the result can be loaded
        if (out_free) begin
          vld_we   = 1'b1;
          dat_we   = 1'b1;
          vld_wd   = upd_vld;
          dat_wd   = upd_row;
          out_load = 1'b1;
          res      = upd_res;
          state_d  = tft_pkg::CS_IDLE;
        end
      end
      tft_pkg::CS_SCAN: begin
        wr_addr = scan_row_q;
        if (d_found) begin
          if (out_free) begin
            vld_we             = 1'b1;
            vld_wd             = vld_rd_q & ~(WAYS'(1) << dw);
            out_load           = 1'b1;
            res.record_valid   = 1'b1;
            res.flow_src_ip    = d_ent.src_ip;
            res.flow_src_port  = d_ent.src_port;
            res.flow_dst_ip    = d_ent.dst_ip;
            res.flow_dst_port  = d_ent.dst_port;
            res.up_bytes       = d_ent.up_bytes;
            res.down_bytes     = d_ent.down_bytes;
            res.up_packets     = d_ent.up_packets;
            res.down_packets   = d_ent.down_packets;
            res.final_state    = d_ent.tstate;
            if (dw == WB'(WAYS - 1)) begin
              cur_way_d = '0;
              cur_row_d = scan_row_nx;
            end else begin
              cur_way_d = dw + WB'(1);
              cur_row_d = scan_row_q;
            end
            state_d = tft_pkg::CS_IDLE;
          end
        end else if (scan_cnt_q == CB'(SETS)) begin
          if (out_free) begin
            out_load        = 1'b1;
            res.table_empty = 1'b1;
            state_d         = tft_pkg::CS_IDLE;
          end
        end else begin
          rd_en      = 1'b1;
          rd_addr    = scan_row_nx;
          scan_row_d = scan_row_nx;
          scan_cnt_d = scan_cnt_q + CB'(1);
        end
      end
      default: state_d = tft_pkg::CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tft_pkg::CS_CLEAR;
      clr_row_q   <= '0;
      scan_row_q  <= '0;
      scan_cnt_q  <= '0;
      cur_row_q   <= '0;
      cur_way_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_row_q  <= clr_row_d;
      scan_row_q <= scan_row_d;
      scan_cnt_q <= scan_cnt_d;
      cur_row_q  <= cur_row_d;
      cur_way_q  <= cur_way_d;
      if (out_load)         out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept)   in_q  <= in_data_i;
    if (out_load) out_q <= res;
  end

  `TFT_ASSERT_IMP(a_load_state, out_load, (state_q == tft_pkg::CS_UPDATE) || (state_q == tft_pkg::CS_SCAN), "result loaded outside update or scan")
  `TFT_ASSERT_NXT(a_load_shows, out_load, out_valid_o, "loaded result not presented")
  `TFT_ASSERT_IMP(a_scan_bound, state_q == tft_pkg::CS_SCAN, scan_cnt_q <= CB'(SETS), "drain scan ran past the table")
  `TFT_ASSERT_IMP(a_no_overwrite, out_load, out_free, "pending result overwritten")

endmodule

@@ rtl/tft_set_index.sv @@
// ----------------------------------------------------------------------------
// tft_set_index
// Two-stage flow hash and set index: hash, then reduction mod SETS by
// reciprocal multiply. Result is valid once hash_q and then quot_q hold the settled tuple.
// ----------------------------------------------------------------------------
module tft_set_index #(
  parameter int unsigned SETS = tft_pkg::SETS_DEF,
  localparam int unsigned RB  = (SETS > 1) ? $clog2(SETS) : 1
) (
  input  logic          clk_i,
  input  tft_pkg::in_t  tuple_i,
  output logic [RB-1:0] set_idx_o
);

  // ceil(2^32 / SETS); exact quotient for any 16-bit hash
  localparam logic [32:0] RECIP = 33'(((64'd1 << 32) + 64'(SETS) - 64'd1) / 64'(SETS));

  logic [31:0] prod;
  logic [31:0] mix;
  logic [15:0] hash_d, hash_q;
  logic [48:0] qprod;
  logic [15:0] quot_q;
  logic [32:0] back;
  logic [32:0] rem;

  assign prod   = 32'(tuple_i.src_port) * 32'(tuple_i.dst_port);
  assign mix    = tuple_i.src_ip ^ tuple_i.dst_ip ^ prod;
  assign hash_d = {8'h00, mix[7:0]} ^ mix[31:16];

  assign qprod = 49'(hash_q) * 49'(RECIP);

  always_ff @(posedge clk_i) begin
    hash_q <= hash_d;
    quot_q <= qprod[47:32];
  end

  assign back      = 33'(quot_q) * 33'(SETS);
  assign rem       = 33'(hash_q) - back;
  assign set_idx_o = rem[RB-1:0];

endmodule

@@ verif/tb_tcp_flow_tracker.sv @@
// ----------------------------------------------------------------------------
// tb_tcp_flow_tracker
// Self-checking bench for the TCP flow tracker. A flow table model predicts
// one record per transaction (packet update or drain). Stimulus opens flows,
// walks them through FIN/ACK teardown in both directions, fills sets until
// packets drop, and drains the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_tcp_flow_tracker;

  localparam int unsigned NSETS   = tft_pkg::SETS_DEF;
  localparam int unsigned NWAYS   = tft_pkg::WAYS_DEF;
  localparam int unsigned NENTRY  = NSETS * NWAYS;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  tft_pkg::in_t  in_data_i = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  tft_pkg::out_t out_data_o;

  tcp_flow_tracker uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // flow table model
  bit              tbl_valid [NENTRY];
  tft_pkg::entry_t tbl_entry [NENTRY];
  int unsigned     drain_ptr;

  tft_pkg::in_t  pkt_queue [$];
  tft_pkg::out_t record_queue [$];
  int   err_count;
  bit   stim_done;
  bit   idle_ok;
  bit   in_acc;
  bit   hold_go;
  bit   hold_on;
  bit   hold_done;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hffff_ffff : s[31:0];
  endfunction

  function automatic int unsigned set_base(tft_pkg::in_t p);
    logic [31:0] r;
    logic [31:0] prod;
    logic [15:0] h;
    prod = 32'(p.src_port) * 32'(p.dst_port);
    r = p.src_ip ^ p.dst_ip ^ prod;
    h = 16'((r & 32'h00ff) ^ (r >> 16));
    return (int'(h) % NSETS) * NWAYS;
  endfunction

  function automatic tft_pkg::out_t give_entry(int unsigned i, logic [3:0] st);
    tft_pkg::out_t o;
    o = '0;
    o.record_valid  = 1'b1;
    o.flow_src_ip   = tbl_entry[i].src_ip;
    o.flow_src_port = tbl_entry[i].src_port;
    o.flow_dst_ip   = tbl_entry[i].dst_ip;
    o.flow_dst_port = tbl_entry[i].dst_port;
    o.up_bytes      = tbl_entry[i].up_bytes;
    o.down_bytes    = tbl_entry[i].down_bytes;
    o.up_packets    = tbl_entry[i].up_packets;
    o.down_packets  = tbl_entry[i].down_packets;
    o.final_state   = st;
    tbl_valid[i] = 1'b0;
    return o;
  endfunction

  function automatic tft_pkg::out_t predict_record(tft_pkg::in_t p);
    tft_pkg::out_t o;
    int unsigned base, freeway, i;
    bit up, dn;
    logic [3:0] st;
    o = '0;
    if (p.op == tft_pkg::OP_DRAIN) begin
      for (int k = 0; k < NENTRY; k++) begin
        i = (drain_ptr + k) % NENTRY;
        if (tbl_valid[i]) begin
          drain_ptr = (i + 1) % NENTRY;
          return give_entry(i, tbl_entry[i].tstate);
        end
      end
      o.table_empty = 1'b1;
      return o;
    end
    base = set_base(p);
    freeway = NENTRY;
    for (int k = 0; k < NWAYS; k++) begin
      i = base + k;
      if (!tbl_valid[i]) begin
        if (freeway == NENTRY) freeway = i;
        continue;
      end
      up = tbl_entry[i].src_ip == p.src_ip && tbl_entry[i].dst_ip == p.dst_ip &&
           tbl_entry[i].src_port == p.src_port && tbl_entry[i].dst_port == p.dst_port;
      dn = tbl_entry[i].dst_ip == p.src_ip && tbl_entry[i].src_ip == p.dst_ip &&
           tbl_entry[i].dst_port == p.src_port && tbl_entry[i].src_port == p.dst_port;
      if (!up && !dn) continue;
      st = tbl_entry[i].tstate;
      if (up) begin
        tbl_entry[i].up_bytes = sat_sum(tbl_entry[i].up_bytes, 32'(p.payload_len));
        tbl_entry[i].up_packets = sat_sum(tbl_entry[i].up_packets, 32'd1);
        if (st == tft_pkg::ST_ESTAB && p.fin_flag)
          tbl_entry[i].tstate = tft_pkg::ST_FIN_WAIT_1;
        else if (st == tft_pkg::ST_TIME_WAIT && p.ack_flag)
          o = give_entry(i, tft_pkg::ST_CLOSED);
        else if (st == tft_pkg::ST_CLOSE_WAIT && p.fin_flag)
          tbl_entry[i].tstate = tft_pkg::ST_LAST_ACK;
      end else begin
        tbl_entry[i].down_bytes = sat_sum(tbl_entry[i].down_bytes, 32'(p.payload_len));
        tbl_entry[i].down_packets = sat_sum(tbl_entry[i].down_packets, 32'd1);
        if (st == tft_pkg::ST_ESTAB && p.fin_flag)
          tbl_entry[i].tstate = tft_pkg::ST_CLOSE_WAIT;
        else if (st == tft_pkg::ST_LAST_ACK && p.ack_flag)
          o = give_entry(i, tft_pkg::ST_CLOSED);
        else if (st == tft_pkg::ST_FIN_WAIT_1 && p.ack_flag)
          tbl_entry[i].tstate = tft_pkg::ST_FIN_WAIT_2;
        else if (st == tft_pkg::ST_FIN_WAIT_2 && p.fin_flag)
          tbl_entry[i].tstate = tft_pkg::ST_TIME_WAIT;
      end
      return o;
    end
    if (freeway == NENTRY) begin
      o.dropped = 1'b1;
      return o;
    end
    tbl_valid[freeway] = 1'b1;
    tbl_entry[freeway] = '{src_ip: p.src_ip, dst_ip: p.dst_ip, src_port: p.src_port,
                           dst_port: p.dst_port, up_bytes: 32'(p.payload_len),
                           down_bytes: 32'd0, up_packets: 32'd1, down_packets: 32'd0,
                           tstate: tft_pkg::ST_ESTAB};
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // stimulus helpers
  function automatic tft_pkg::in_t mk_pkt(logic [31:0] sip, logic [31:0] dip,
                                          logic [15:0] sp, logic [15:0] dp,
                                          logic [15:0] len, bit fin, bit ack);
    tft_pkg::in_t p;
    p = '{op: tft_pkg::OP_PACKET, src_ip: sip, dst_ip: dip, src_port: sp, dst_port: dp,
          payload_len: len, fin_flag: fin, ack_flag: ack};
    return p;
  endfunction

  function automatic tft_pkg::in_t mk_drain();
    tft_pkg::in_t p;
    p = '0;
    p.op = tft_pkg::OP_DRAIN;
    p.src_ip = $urandom();
    p.dst_ip = $urandom();
    p.payload_len = 16'($urandom());
    p.fin_flag = 1'($urandom());
    p.ack_flag = 1'($urandom());
    return p;
  endfunction

  // one flow's life: open, data both ways, then in most flows a teardown led by either side
  task automatic push_flow(logic [31:0] sip, logic [31:0] dip, logic [15:0] sp,
                           logic [15:0] dp);
    bit active;
    tft_pkg::in_t a, b;
    active = $urandom_range(1, 0);
    a = mk_pkt(sip, dip, sp, dp, 16'($urandom()), 1'b0, 1'b0);
    b = mk_pkt(dip, sip, dp, sp, 16'($urandom()), 1'b0, 1'b0);
    pkt_queue.push_back(a);
    repeat ($urandom_range(3, 0)) begin
      a.payload_len = 16'($urandom());
      b.payload_len = 16'($urandom());
      a.fin_flag = 1'($urandom_range(9, 0) == 0);
      a.ack_flag = 1'($urandom());
      b.ack_flag = 1'($urandom());
      pkt_queue.push_back($urandom_range(1, 0) ? a : b);
    end
    a.fin_flag = 1'b0; b.fin_flag = 1'b0;
    if ($urandom_range(9, 0) == 0) return;
    if (active) begin
      a.fin_flag = 1'b1; pkt_queue.push_back(a); a.fin_flag = 1'b0;
      b.ack_flag = 1'b1; pkt_queue.push_back(b);
      b.fin_flag = 1'b1; pkt_queue.push_back(b);
      a.ack_flag = 1'b1; pkt_queue.push_back(a);
    end else begin
      b.fin_flag = 1'b1; pkt_queue.push_back(b); b.fin_flag = 1'b0;
      a.fin_flag = 1'b1; pkt_queue.push_back(a);
      b.ack_flag = 1'b1; pkt_queue.push_back(b);
    end
  endtask

  // driver; in_acc marks a transaction taken at the last rising edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_acc) begin
        if (in_acc) void'(pkt_queue.pop_front());
        if (pkt_queue.size() != 0 && (idle_ok ? $urandom_range(99, 0) >= 31 : 1'b1)) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pkt_queue[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if (hold_on) begin
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= idle_ok ? ($urandom_range(99, 0) < 31) : 1'b0;
      end
    end
  end

  // long receiver hold-off, counted here
  initial begin
    hold_on = 1'b0;
    hold_done = 1'b0;
    wait (hold_go);
    hold_on = 1'b1;
    repeat (400) @(negedge clk_i);
    hold_on = 1'b0;
    hold_done = 1'b1;
  end

  // predictor runs on accepted input; checker on accepted output
  always @(posedge clk_i) begin
    tft_pkg::out_t want;
    in_acc = rst_ni && in_valid_i && !in_stall_o;
    if (in_acc) record_queue.push_back(predict_record(in_data_i));
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (record_queue.size() == 0) begin
        report_mismatch("unexpected record", 64'(out_data_o.record_valid), 64'd0);
      end else begin
        want = record_queue.pop_front();
        if (out_data_o.record_valid !== want.record_valid)
          report_mismatch("record_valid", 64'(out_data_o.record_valid), 64'(want.record_valid));
        if (out_data_o.flow_src_ip !== want.flow_src_ip)
          report_mismatch("flow_src_ip", 64'(out_data_o.flow_src_ip), 64'(want.flow_src_ip));
        if (out_data_o.flow_src_port !== want.flow_src_port)
          report_mismatch("flow_src_port", 64'(out_data_o.flow_src_port),
                          64'(want.flow_src_port));
        if (out_data_o.flow_dst_ip !== want.flow_dst_ip)
          report_mismatch("flow_dst_ip", 64'(out_data_o.flow_dst_ip), 64'(want.flow_dst_ip));
        if (out_data_o.flow_dst_port !== want.flow_dst_port)
          report_mismatch("flow_dst_port", 64'(out_data_o.flow_dst_port),
                          64'(want.flow_dst_port));
        if (out_data_o.up_bytes !== want.up_bytes)
          report_mismatch("up_bytes", 64'(out_data_o.up_bytes), 64'(want.up_bytes));
        if (out_data_o.down_bytes !== want.down_bytes)
          report_mismatch("down_bytes", 64'(out_data_o.down_bytes), 64'(want.down_bytes));
        if (out_data_o.up_packets !== want.up_packets)
          report_mismatch("up_packets", 64'(out_data_o.up_packets), 64'(want.up_packets));
        if (out_data_o.down_packets !== want.down_packets)
          report_mismatch("down_packets", 64'(out_data_o.down_packets),
                          64'(want.down_packets));
        if (out_data_o.final_state !== want.final_state)
          report_mismatch("final_state", 64'(out_data_o.final_state), 64'(want.final_state));
        if (out_data_o.dropped !== want.dropped)
          report_mismatch("dropped", 64'(out_data_o.dropped), 64'(want.dropped));
        if (out_data_o.table_empty !== want.table_empty)
          report_mismatch("table_empty", 64'(out_data_o.table_empty), 64'(want.table_empty));
      end
    end
  end

  initial begin
    tft_pkg::in_t p;
    logic [31:0] sip, dip;
    logic [15:0] sp, dp;
    err_count = 0;
    stim_done = 1'b0;
    idle_ok = 1'b1;
    hold_go = 1'b0;
    drain_ptr = 0;
    // directed: empty drain, extremes, self-flow, teardown both ways
    pkt_queue.push_back(mk_drain());
    pkt_queue.push_back(mk_pkt('1, '1, '1, '1, '1, 1'b1, 1'b1));
    pkt_queue.push_back(mk_pkt('1, '1, '1, '1, '1, 1'b1, 1'b0));
    pkt_queue.push_back(mk_pkt('0, '0, '0, '0, '0, 1'b0, 1'b0));
    pkt_queue.push_back(mk_pkt(32'h0a000001, 32'h0a000002, 16'd80, 16'd1234, 16'd100, 0, 1));
    pkt_queue.push_back(mk_pkt(32'h0a000002, 32'h0a000001, 16'd1234, 16'd80, 16'hffff, 1, 0));
    pkt_queue.push_back(mk_pkt(32'h0a000001, 32'h0a000002, 16'd80, 16'd1234, 16'd5, 1, 0));
    pkt_queue.push_back(mk_pkt(32'h0a000002, 32'h0a000001, 16'd1234, 16'd80, 16'd0, 0, 1));
    // five flows in one set (port 0 keeps the hash on addresses): the zero flow holds a way, so the last two drop
    for (int k = 0; k < 5; k++)
      pkt_queue.push_back(mk_pkt(32'h100 << k, 32'h100 << k, 16'd7, 16'd0, 16'd1, 0, 0));
    pkt_queue.push_back(mk_pkt(32'h5500_0000, 32'h5500_0000, 16'd0, 16'd0, '1, 0, 0));
    for (int k = 0; k < 6; k++) pkt_queue.push_back(mk_drain());
    // random flows, noise and drains
    while (pkt_queue.size() < 1750) begin
      case ($urandom_range(9, 0))
        0, 1: pkt_queue.push_back(mk_drain());
        2: begin
          p = mk_pkt($urandom(), $urandom(), 16'($urandom()), 16'($urandom()),
                     16'($urandom()), 1'($urandom()), 1'($urandom()));
          pkt_queue.push_back(p);
        end
        default: begin
          // narrow address pool so sets collide and fill
          sip = $urandom_range(1, 0) ? $urandom() : 32'($urandom_range(63, 0));
          dip = $urandom_range(1, 0) ? $urandom() : 32'($urandom_range(63, 0));
          sp = 16'($urandom());
          dp = $urandom_range(3, 0) == 0 ? 16'd0 : 16'($urandom());
          push_flow(sip, dip, sp, dp);
        end
      endcase
    end
    // final drains to empty what is left of the table
    repeat (40) pkt_queue.push_back(mk_drain());
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // wait out the clearing pass, then a stretch with no idling and a long
    // receiver hold
    idle_ok = 1'b0;
    @(posedge clk_i);
    wait (in_stall_o == 1'b0);
    repeat (300) @(posedge clk_i);
    hold_go = 1'b1;
    wait (hold_done);
    idle_ok = 1'b1;
    wait (pkt_queue.size() == 0);
    while (record_queue.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (err_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #20000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/tft_pkg.sv
rtl/tft_set_index.sv
rtl/tcp_flow_tracker.sv
verif/tb_tcp_flow_tracker.sv
